@@ rtl/core/upd_pkg.sv @@
// Shared types and character constants for the URL percent decoder.
// Used by upd_decode and url_percent_decoder_core; no dependencies.

package upd_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Results produced by one input item: a count (0 to 2) and the bytes in order.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } dec_res_t;

endpackage

@@ rtl/core/url_percent_decoder_core.sv @@
// Streaming URL percent decoder: top level with input register and a
// two-entry result buffer. Depends on upd_pkg and upd_decode.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_ready, in_byte, in_end_of_string | sink
//  out     | out_valid, out_ready, out_byte, out_run_end,  | source
//          | out_string_end                                |
//
// An item is registered on acceptance and decoded into the result buffer once
// the buffer can take it, so one item per cycle is sustained while results drain
// at one per cycle. A malformed escape yields two results and stalls input while
// both wait on the single result port. The first result of an item is presented
// from the result buffer, after the item has passed the input register.
// Reset clears the escape phase, the input register and the result buffer.

module url_percent_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_string_end
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] s0_byte_r, s0_byte_nxt;
  logic       s0_run_r, s0_run_nxt;
  logic       s0_str_r, s0_str_nxt;
  logic [7:0] s1_byte_r, s1_byte_nxt;
  logic       s1_str_r, s1_str_nxt;

  logic              pop;
  logic              out_free;
  logic              consume;
  upd_pkg::dec_res_t res;

  assign pop      = out_valid && out_ready;
  assign out_free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign consume  = in_vld_r && out_free;
  assign in_ready = !in_vld_r || consume;

  upd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (consume),
    .in_byte (in_byte_r),
    .in_last (in_last_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
      in_last_r <= in_end_of_string;
    end
  end

  // A load only happens when the buffer is empty after this cycle's pop.
  always_comb begin
    cnt_nxt     = cnt_r;
    s0_byte_nxt = s0_byte_r;
    s0_run_nxt  = s0_run_r;
    s0_str_nxt  = s0_str_r;
    s1_byte_nxt = s1_byte_r;
    s1_str_nxt  = s1_str_r;
    if (consume) begin
      cnt_nxt     = res.count;
      s0_byte_nxt = res.byte0;
      s0_run_nxt  = (res.count == 2'd1);
      s0_str_nxt  = in_last_r && (res.count == 2'd1);
      s1_byte_nxt = res.byte1;
      s1_str_nxt  = in_last_r;
    end else if (pop) begin
      cnt_nxt     = cnt_r - 2'd1;
      s0_byte_nxt = s1_byte_r;
      s0_run_nxt  = 1'b1;
      s0_str_nxt  = s1_str_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_byte_r <= s0_byte_nxt;
    s0_run_r  <= s0_run_nxt;
    s0_str_r  <= s0_str_nxt;
    s1_byte_r <= s1_byte_nxt;
    s1_str_r  <= s1_str_nxt;
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_byte       = s0_byte_r;
  assign out_run_end    = s0_run_r;
  assign out_string_end = s0_str_r;

endmodule

@@ rtl/core/upd_decode.sv @@
// Escape decoder: holds the escape phase and first hex digit, and turns one
// input byte into up to two decoded bytes. Depends on upd_pkg.

module upd_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output upd_pkg::dec_res_t  res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX  = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] nib_r, nib_nxt;

  logic       is_hex;
  logic [3:0] hex_val;
  logic       e0, e1, e2;
  logic [7:0] c0, c1, c2;
  logic       plain_on;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
      hex_val = in_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // Three candidate results in output order: the escape result, the byte
  // itself, and the end-of-string flush. At most two are ever active.
  always_comb begin
    phase_nxt = PH_IDLE;
    nib_nxt   = nib_r;
    e0        = 1'b0;
    c0        = 8'h00;
    plain_on  = 1'b1;
    case (phase_r)
      PH_PCT: begin
        if (is_hex) begin
          nib_nxt   = hex_val;
          phase_nxt = PH_HEX;
          plain_on  = 1'b0;
        end else begin
          e0 = 1'b1;
          c0 = upd_pkg::CHAR_PERCENT;
        end
      end
      PH_HEX: begin
        nib_nxt = 4'd0;
        e0      = 1'b1;
        if (is_hex) begin
          c0       = {nib_r, hex_val};
          plain_on = 1'b0;
        end else begin
          c0 = {4'd0, nib_r};
        end
      end
      default: begin
      end
    endcase

    e1 = 1'b0;
    c1 = in_byte;
    if (plain_on) begin
      if (in_byte == upd_pkg::CHAR_PLUS) begin
        e1 = 1'b1;
        c1 = upd_pkg::CHAR_SPACE;
      end else if (in_byte == upd_pkg::CHAR_PERCENT) begin
        phase_nxt = PH_PCT;
      end else begin
        e1 = 1'b1;
      end
    end

    e2 = in_last && (phase_nxt != PH_IDLE);
    c2 = (phase_nxt == PH_PCT) ? upd_pkg::CHAR_PERCENT : {4'd0, nib_nxt};
    if (in_last) begin
      phase_nxt = PH_IDLE;
      nib_nxt   = 4'd0;
    end

    res.count = {1'b0, e0} + {1'b0, e1} + {1'b0, e2};
    res.byte0 = e0 ? c0 : (e1 ? c1 : c2);
    res.byte1 = (e0 && e1) ? c1 : c2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      nib_r   <= 4'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
    end
  end

endmodule
